/* design/dht_pkg.sv */
// Shared types and codes for the JPEG DHT canonical code builder.
// Holds the request and result structs plus result kind and error codes.
// Depends on nothing.
package dht_pkg;

  localparam logic [1:0] KIND_CODE  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BAD_CLASS = 3'd1;
  localparam logic [2:0] ERR_REDEFINED = 3'd2;
  localparam logic [2:0] ERR_TRUNCATED = 3'd3;
  localparam logic [2:0] ERR_BAD_TREE  = 3'd4;

  typedef struct packed {
    logic [7:0]  seg_byte;
    logic        seg_start;
    logic [15:0] seg_len;
  } byte_req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        table_class;
    logic [3:0]  table_id;
    logic [7:0]  symbol_index;
    logic [4:0]  code_length;
    logic [15:0] code_value;
    logic [7:0]  symbol;
    logic [2:0]  error_code;
    logic        last;
  } result_t;

endpackage

/* design/jpeg_dht_canonical_code_builder.sv */
// JPEG DHT canonical code builder: parses DHT payload bytes and emits codewords.
// Top level; depends on dht_pkg for the request/result structs and codes.
//
// Usage:
//   The byte channel (byte_valid, byte_stall, byte_req) carries one DHT payload
//   byte per request; seg_start marks the first byte of a segment and seg_len is
//   sampled with it. The result channel (result_valid, result_stall, result)
//   carries codeword, table-complete and error results, with last set on the
//   final result caused by a byte.
//   Each byte is parsed in the cycle it is accepted and its zero, one or two
//   results are written into a four-entry registered result queue. One byte
//   is taken per cycle as long as the queue holds at most two results; the
//   queue drains one result per cycle while result_stall is low.
//   The next-length search is a 16-bit priority pick over the nonzero counts.
//   When the receiver stalls, the queue fills and byte_stall rises once fewer
//   than two free slots remain; no result is dropped.
//   Reset clears the parser to waiting for a segment start, empties the queue
//   and forgets all defined tables.
module jpeg_dht_canonical_code_builder #(
  parameter int MAX_SYMBOLS  = 256,
  parameter int MAX_CODE_LEN = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  dht_pkg::byte_req_t byte_req,
  output logic               result_valid,
  input  logic               result_stall,
  output dht_pkg::result_t   result
);
  import dht_pkg::*;

  localparam logic [2:0] PH_WAIT    = 3'd0;
  localparam logic [2:0] PH_HEADER  = 3'd1;
  localparam logic [2:0] PH_COUNTS  = 3'd2;
  localparam logic [2:0] PH_SYMBOLS = 3'd3;
  localparam logic [2:0] PH_SKIP    = 3'd4;

  localparam logic [4:0] MaxLen  = 5'(MAX_CODE_LEN);
  localparam logic [9:0] MaxSyms = 10'(MAX_SYMBOLS);

  // Parser state.
  logic [2:0]  phase, phase_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [7:0]  length_counts [16];
  logic [3:0]  count_index, count_index_next;
  logic [8:0]  total_codes, total_codes_next;
  logic [8:0]  symbols_done, symbols_done_next;
  logic [4:0]  current_length, current_length_next;
  logic [16:0] current_code, current_code_next;
  logic [8:0]  left_at_length, left_at_length_next;
  logic [4:0]  header_id, header_id_next;
  logic [31:0] defined_tables, defined_tables_next;

  // Result queue.
  result_t     queue [4];
  logic [1:0]  wr_ptr, rd_ptr;
  logic [2:0]  count, count_next;

  logic        take, pop;
  logic        count_write;
  logic [1:0]  n_push;
  result_t     res [2];

  logic [15:0] nonzero;
  logic [15:0] search_mask;
  logic [3:0]  pick;
  logic        pick_found;
  logic [7:0]  pick_count;

  function automatic logic [3:0] low_index(input logic [15:0] m);
    logic [3:0] idx;
    idx = '0;
    for (int j = 15; j >= 0; j--) begin
      if (m[j]) idx = 4'(j);
    end
    return idx;
  endfunction

  function automatic result_t make_res(input logic [1:0] kind, input logic [4:0] id5,
                                       input logic [7:0] idx, input logic [4:0] len,
                                       input logic [15:0] code, input logic [7:0] sym,
                                       input logic [2:0] err);
    result_t r;
    r.kind         = kind;
    r.table_class  = id5[4];
    r.table_id     = id5[3:0];
    r.symbol_index = idx;
    r.code_length  = len;
    r.code_value   = code;
    r.symbol       = sym;
    r.error_code   = err;
    r.last         = 1'b0;
    return r;
  endfunction

  assign take         = byte_valid && !byte_stall;
  assign byte_stall   = (count > 3'd2);
  assign result_valid = (count != 3'd0);
  assign result       = queue[rd_ptr];
  assign pop          = result_valid && !result_stall;

  always_comb begin
    for (int j = 0; j < 16; j++) begin
      nonzero[j] = (length_counts[j] != 8'd0);
    end
  end

  always_comb begin
    logic [2:0]  ph;
    logic [15:0] bl;
    logic [7:0]  b;
    logic [4:0]  id5;
    logic [9:0]  sum;
    logic [8:0]  tot;
    logic [8:0]  sd;
    logic [8:0]  left;
    logic [16:0] code;
    logic [4:0]  new_len;
    logic [1:0]  k;

    ph  = phase;
    bl  = bytes_left;
    b   = byte_req.seg_byte;
    id5 = b[4:0];
    sum = '0;
    tot = '0;
    sd  = '0;
    left = '0;
    code = '0;
    new_len = '0;
    k   = '0;

    phase_next          = phase;
    bytes_left_next     = bytes_left;
    count_index_next    = count_index;
    total_codes_next    = total_codes;
    symbols_done_next   = symbols_done;
    current_length_next = current_length;
    current_code_next   = current_code;
    left_at_length_next = left_at_length;
    header_id_next      = header_id;
    defined_tables_next = defined_tables;
    count_write         = 1'b0;
    res[0]              = '0;
    res[1]              = '0;

    if (take && byte_req.seg_start) begin
      bl = byte_req.seg_len;
      ph = (byte_req.seg_len == 16'd0) ? PH_WAIT : PH_HEADER;
    end

    // In the counts phase the pick sees the count being written now.
    search_mask = (ph == PH_COUNTS) ? {(b != 8'd0), nonzero[14:0]}
                                    : (nonzero & (16'hFFFF << current_length));
    pick       = low_index(search_mask);
    pick_found = |search_mask;
    pick_count = (ph == PH_COUNTS && pick == 4'd15) ? b : length_counts[pick];

    if (take) begin
      phase_next      = ph;
      bytes_left_next = bl;
    end

    if (take && (ph == PH_HEADER || ph == PH_COUNTS || ph == PH_SYMBOLS)) begin
      bytes_left_next = bl - 16'd1;
      unique case (ph)
        PH_HEADER: begin
          if (b[7:4] > 4'd1) begin
            res[k[0]] = make_res(KIND_ERROR, id5, '0, '0, '0, '0, ERR_BAD_CLASS);
            k = k + 2'd1;
            phase_next = PH_SKIP;
          end else if (defined_tables[id5]) begin
            res[k[0]] = make_res(KIND_ERROR, id5, '0, '0, '0, '0, ERR_REDEFINED);
            k = k + 2'd1;
            phase_next = PH_SKIP;
          end else begin
            defined_tables_next[id5] = 1'b1;
            header_id_next   = id5;
            count_index_next = '0;
            total_codes_next = '0;
            phase_next       = PH_COUNTS;
          end
        end
        PH_COUNTS: begin
          count_write = 1'b1;
          if (b != 8'd0 && (count_index == 4'd0 ||
                            ({1'b0, count_index} + 5'd1) > MaxLen)) begin
            res[k[0]] = make_res(KIND_ERROR, header_id, '0, '0, '0, '0, ERR_BAD_TREE);
            k = k + 2'd1;
            phase_next = PH_SKIP;
          end else begin
            sum = {1'b0, total_codes} + {2'b00, b};
            tot = (sum > 10'd511) ? 9'd511 : sum[8:0];
            total_codes_next = tot;
            if (count_index < 4'd15) begin
              count_index_next = count_index + 4'd1;
            end else if ({1'b0, tot} > MaxSyms) begin
              res[k[0]] = make_res(KIND_ERROR, header_id, '0, '0, '0, '0, ERR_BAD_TREE);
              k = k + 2'd1;
              phase_next = PH_SKIP;
            end else if (tot == 9'd0) begin
              res[k[0]] = make_res(KIND_DONE, header_id, '0, '0, '0, '0, ERR_NONE);
              k = k + 2'd1;
              phase_next = PH_HEADER;
            end else begin
              current_length_next = {1'b0, pick} + 5'd1;
              left_at_length_next = {1'b0, pick_count};
              current_code_next   = '0;
              symbols_done_next   = '0;
              phase_next          = PH_SYMBOLS;
            end
          end
        end
        PH_SYMBOLS: begin
          if ((current_code >> current_length) != 17'd0) begin
            res[k[0]] = make_res(KIND_ERROR, header_id, '0, '0, '0, '0, ERR_BAD_TREE);
            k = k + 2'd1;
            phase_next = PH_SKIP;
          end else begin
            res[k[0]] = make_res(KIND_CODE, header_id, symbols_done[7:0], current_length,
                                 current_code[15:0], b, ERR_NONE);
            k = k + 2'd1;
            sd   = symbols_done + 9'd1;
            left = left_at_length - 9'd1;
            symbols_done_next   = sd;
            left_at_length_next = left;
            if (sd >= total_codes) begin
              res[k[0]] = make_res(KIND_DONE, header_id, '0, '0, '0, '0, ERR_NONE);
              k = k + 2'd1;
              phase_next = PH_HEADER;
            end else begin
              code = current_code + 17'd1;
              current_code_next = code;
              if (left == 9'd0) begin
                if (!pick_found) begin
                  res[k[0]] = make_res(KIND_ERROR, header_id, '0, '0, '0, '0,
                                       ERR_BAD_TREE);
                  k = k + 2'd1;
                  phase_next = PH_SKIP;
                end else begin
                  new_len = {1'b0, pick} + 5'd1;
                  current_length_next = new_len;
                  left_at_length_next = {1'b0, pick_count};
                  current_code_next   = code << (new_len - current_length);
                end
              end
            end
          end
        end
        default: begin
        end
      endcase

      // Segment ends with this byte.
      if (bytes_left_next == 16'd0) begin
        if (phase_next == PH_COUNTS || phase_next == PH_SYMBOLS) begin
          res[k[0]] = make_res(KIND_ERROR, header_id_next, '0, '0, '0, '0, ERR_TRUNCATED);
          k = k + 2'd1;
          phase_next = PH_SKIP;
        end else if (phase_next == PH_HEADER) begin
          phase_next = PH_WAIT;
        end
      end
    end

    if (k != 2'd0) begin
      res[k[1]].last = 1'b1;
    end
    n_push = k;
  end

  assign count_next = count + {1'b0, n_push} - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_WAIT;
      bytes_left     <= '0;
      count_index    <= '0;
      total_codes    <= '0;
      symbols_done   <= '0;
      current_length <= '0;
      current_code   <= '0;
      left_at_length <= '0;
      header_id      <= '0;
      defined_tables <= '0;
      wr_ptr         <= '0;
      rd_ptr         <= '0;
      count          <= '0;
    end else begin
      phase          <= phase_next;
      bytes_left     <= bytes_left_next;
      count_index    <= count_index_next;
      total_codes    <= total_codes_next;
      symbols_done   <= symbols_done_next;
      current_length <= current_length_next;
      current_code   <= current_code_next;
      left_at_length <= left_at_length_next;
      header_id      <= header_id_next;
      defined_tables <= defined_tables_next;
      wr_ptr         <= wr_ptr + n_push;
      rd_ptr         <= rd_ptr + {1'b0, pop};
      count          <= count_next;
    end
  end

  // Payload storage: the count table and the result queue need no reset.
  always_ff @(posedge clk) begin
    if (count_write) begin
      length_counts[count_index] <= byte_req.seg_byte;
    end
    if (n_push != 2'd0) begin
      queue[wr_ptr] <= res[0];
    end
    if (n_push == 2'd2) begin
      queue[wr_ptr + 2'd1] <= res[1];
    end
  end

endmodule

/* test/tb_top.sv */
// Self-checking testbench for jpeg_dht_canonical_code_builder.
// Streams DHT payload bytes, predicts each result with an independent parser
// and checks the results in order. Depends on dht_pkg and the builder RTL.

import dht_pkg::*;

class code_table_scoreboard #(int SYM_LIMIT = 256, int LEN_LIMIT = 16);
  typedef enum logic [2:0] {PS_WAIT, PS_HEADER, PS_COUNTS, PS_SYMBOLS, PS_SKIP} parse_state_t;

  parse_state_t state;
  logic [15:0]  bytes_left;
  logic [7:0]   len_count[16];
  logic [3:0]   count_idx;
  logic [8:0]   total_codes;
  logic [8:0]   symbols_done;
  logic [4:0]   cur_len;
  logic [16:0]  cur_code;
  logic [8:0]   left_at_len;
  logic [4:0]   table_sel;
  logic [31:0]  defined;

  result_t expected_q[$];
  result_t step_q[$];
  int      mismatches;
  int      codes_seen;
  int      tables_seen;
  int      errors_seen;
  int      bytes_seen;

  function new();
    state = PS_WAIT;
    bytes_left = '0;
    foreach (len_count[i]) len_count[i] = '0;
    count_idx = '0;
    total_codes = '0;
    symbols_done = '0;
    cur_len = '0;
    cur_code = '0;
    left_at_len = '0;
    table_sel = '0;
    defined = '0;
    mismatches = 0;
    codes_seen = 0;
    tables_seen = 0;
    errors_seen = 0;
    bytes_seen = 0;
  endfunction

  function void add_result(logic [1:0] kind, logic [4:0] sel, logic [7:0] idx, logic [4:0] len,
                           logic [15:0] code, logic [7:0] sym, logic [2:0] err);
    result_t r;
    r.kind = kind;
    r.table_class = sel[4];
    r.table_id = sel[3:0];
    r.symbol_index = idx;
    r.code_length = len;
    r.code_value = code;
    r.symbol = sym;
    r.error_code = err;
    r.last = 1'b0;
    step_q.push_back(r);
  endfunction

  function void fail_table(logic [4:0] sel, logic [2:0] err);
    add_result(KIND_ERROR, sel, '0, '0, '0, '0, err);
    state = PS_SKIP;
  endfunction

  function void finish_table();
    add_result(KIND_DONE, table_sel, '0, '0, '0, '0, ERR_NONE);
    state = PS_HEADER;
  endfunction

  // Index of the first nonzero count at or above the given one, 16 if none.
  function int first_used_len(int from);
    int i;
    i = from;
    while (i < 16 && len_count[i] == 0) i++;
    return i;
  endfunction

  function void note_request(byte_req_t r);
    logic [7:0] b;
    int         sum;
    int         pos;
    b = r.seg_byte;
    bytes_seen++;
    step_q.delete();
    if (r.seg_start) begin
      bytes_left = r.seg_len;
      state = (r.seg_len == 0) ? PS_WAIT : PS_HEADER;
    end
    if (!(state inside {PS_HEADER, PS_COUNTS, PS_SYMBOLS})) return;
    bytes_left = bytes_left - 16'd1;

    case (state)
      PS_HEADER: begin
        if (b[7:4] > 4'd1) begin
          fail_table(b[4:0], ERR_BAD_CLASS);
        end else if (defined[b[4:0]]) begin
          fail_table(b[4:0], ERR_REDEFINED);
        end else begin
          defined[b[4:0]] = 1'b1;
          table_sel = b[4:0];
          count_idx = '0;
          total_codes = '0;
          state = PS_COUNTS;
        end
      end
      PS_COUNTS: begin
        len_count[count_idx] = b;
        if (b != 0 && (count_idx == 0 || int'(count_idx) + 1 > LEN_LIMIT)) begin
          fail_table(table_sel, ERR_BAD_TREE);
        end else begin
          sum = int'(total_codes) + int'(b);
          total_codes = (sum > 511) ? 9'd511 : sum[8:0];
          if (count_idx < 4'd15) begin
            count_idx++;
          end else if (total_codes > SYM_LIMIT) begin
            fail_table(table_sel, ERR_BAD_TREE);
          end else if (total_codes == 0) begin
            finish_table();
          end else begin
            pos = first_used_len(0);
            cur_len = 5'(pos + 1);
            left_at_len = {1'b0, len_count[pos]};
            cur_code = '0;
            symbols_done = '0;
            state = PS_SYMBOLS;
          end
        end
      end
      PS_SYMBOLS: begin
        if (int'(cur_code) >= (1 << cur_len)) begin
          fail_table(table_sel, ERR_BAD_TREE);
        end else begin
          add_result(KIND_CODE, table_sel, symbols_done[7:0], cur_len, cur_code[15:0], b,
                     ERR_NONE);
          symbols_done++;
          left_at_len--;
          if (symbols_done >= total_codes) begin
            finish_table();
          end else begin
            cur_code++;
            if (left_at_len == 0) begin
              // Move to the next length that has codes and widen the code.
              pos = first_used_len(cur_len);
              if (pos >= 16) begin
                fail_table(table_sel, ERR_BAD_TREE);
              end else begin
                cur_code = cur_code << (pos + 1 - cur_len);
                cur_len = 5'(pos + 1);
                left_at_len = {1'b0, len_count[pos]};
              end
            end
          end
        end
      end
      default: ;
    endcase

    if (bytes_left == 0) begin
      if (state == PS_COUNTS || state == PS_SYMBOLS) begin
        fail_table(table_sel, ERR_TRUNCATED);
      end else if (state == PS_HEADER) begin
        state = PS_WAIT;
      end
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    foreach (step_q[i]) expected_q.push_back(step_q[i]);
  endfunction

  function void check_field(string field, logic [15:0] want_v, logic [15:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", field, want_v, got_v);
      mismatches++;
    end
  endfunction

  function void check_result(result_t got);
    result_t want;
    if (expected_q.size() == 0) begin
      $error("result with none expected: kind %0d, table %0d", got.kind, got.table_id);
      mismatches++;
      return;
    end
    want = expected_q.pop_front();
    check_field("kind", want.kind, got.kind);
    check_field("table_class", want.table_class, got.table_class);
    check_field("table_id", want.table_id, got.table_id);
    check_field("symbol_index", want.symbol_index, got.symbol_index);
    check_field("code_length", want.code_length, got.code_length);
    check_field("code_value", want.code_value, got.code_value);
    check_field("symbol", want.symbol, got.symbol);
    check_field("error_code", want.error_code, got.error_code);
    check_field("last", want.last, got.last);
    case (want.kind)
      KIND_CODE: codes_seen++;
      KIND_DONE: tables_seen++;
      default:   errors_seen++;
    endcase
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_top;
  localparam int MAX_SYMS      = 256;
  localparam int MAX_LEN       = 16;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PLAN_LONG_CODES  = 0;
  localparam int PLAN_ALL_SYMBOLS = 1;

  logic      clk;
  logic      rst = 1'b1;
  logic      byte_valid = 1'b0;
  logic      byte_stall;
  byte_req_t byte_req = '0;
  logic      result_valid;
  logic      result_stall = 1'b0;
  result_t   result;

  int          send_idle_pct = 25;
  int          recv_idle_pct = 87;
  int          cycles = 0;
  int          table_bytes_sent = 0;
  bit          open_seg = 1'b0;
  logic [7:0]  seg_q[$];
  logic [31:0] claimed;
  int          len_plan[16];

  code_table_scoreboard #(MAX_SYMS, MAX_LEN) sb;

  jpeg_dht_canonical_code_builder #(
    .MAX_SYMBOLS (MAX_SYMS),
    .MAX_CODE_LEN(MAX_LEN)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .byte_req    (byte_req),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && result_valid && !result_stall) sb.check_result(result);
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] data, input logic first_byte,
                           input logic [15:0] len);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      @(negedge clk);
    end
    byte_valid <= 1'b1;
    byte_req <= '{seg_byte: data, seg_start: first_byte, seg_len: len};
    do @(posedge clk); while (byte_stall);
    sb.note_request(byte_req);
    @(negedge clk);
  endtask

  task automatic send_segment(input logic [15:0] len, input int count);
    for (int i = 0; i < count; i++)
      send_byte(seg_q[i], i == 0, (i == 0) ? len : 16'($urandom));
    table_bytes_sent += count;
    seg_q.delete();
  endtask

  task automatic pause_until_drained();
    byte_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic int free_slot_count();
    return 32 - $countones(sb.defined | claimed);
  endfunction

  function automatic logic [7:0] claim_header();
    int slot;
    slot = $urandom_range(31);
    while (sb.defined[slot] || claimed[slot]) slot = (slot + 1) % 32;
    claimed[slot] = 1'b1;
    return {3'b000, 5'(slot)};
  endfunction

  // Spreads n codes over the lengths so that the tree never overflows, except
  // that whatever is left lands on length 16.
  function automatic int plan_valid(int n, int first_len);
    int room;
    int c;
    int left;
    room = 1;
    left = n;
    for (int l = 1; l <= 16; l++) begin
      room = (room > 65536) ? room : room * 2;
      c = 0;
      if (l >= first_len && l >= 2 && left > 0) begin
        if (l == 16) begin
          c = left;
        end else begin
          c = $urandom_range(0, (left < room) ? left : room);
          if (c == room && c < left) c--;
        end
      end
      if (c > 255) c = 255;
      len_plan[l - 1] = c;
      left -= c;
      room -= c;
    end
    return n - left;
  endfunction

  task automatic append_table(input logic [7:0] header, input int n);
    seg_q.push_back(header);
    foreach (len_plan[i]) seg_q.push_back(8'(len_plan[i]));
    repeat (n) seg_q.push_back(8'($urandom));
  endtask

  task automatic build_table(input logic [7:0] header);
    int mode;
    int n;
    int l;
    foreach (len_plan[i]) len_plan[i] = 0;
    mode = $urandom_range(99);
    if (mode < 72) begin
      n = ($urandom_range(3) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 120);
      n = plan_valid(n, ($urandom_range(4) == 0) ? $urandom_range(9, 16) : 2);
    end else if (mode < 84) begin
      // Either too many codes at one length or an overflow on the shift to the next.
      l = $urandom_range(2, 5);
      len_plan[l - 1] = (1 << l) + $urandom_range(0, 2);
      len_plan[l] = $urandom_range(1, 3);
      n = len_plan[l - 1] + len_plan[l];
    end else if (mode < 90) begin
      foreach (len_plan[i]) if (i >= 8) len_plan[i] = $urandom_range(40, 255);
      n = $urandom_range(0, 3);
    end else if (mode < 95) begin
      len_plan[0] = $urandom_range(1, 255);
      len_plan[1] = $urandom_range(0, 3);
      n = $urandom_range(0, 3);
    end else begin
      n = 0;
    end
    append_table(header, n);
  endtask

  task automatic exact_table(input int plan_kind);
    logic [7:0] header;
    claimed = '0;
    header = claim_header();
    foreach (len_plan[i]) len_plan[i] = 0;
    if (plan_kind == PLAN_LONG_CODES) begin
      // Complete tree whose last two codes are 16 bits wide, ending in all ones.
      len_plan[1] = 3;
      for (int i = 2; i < 15; i++) len_plan[i] = 1;
      len_plan[15] = 2;
      append_table(header, 18);
    end else begin
      len_plan[7] = 255;
      len_plan[8] = 1;
      append_table(header, MAX_SYMS);
    end
    send_segment(16'(seg_q.size()), seg_q.size());
    open_seg = 1'b0;
  endtask

  task automatic table_segment();
    int tables;
    int full;
    int len;
    int count;
    int shape;
    claimed = '0;
    tables = $urandom_range(1, 3);
    for (int t = 0; t < tables && free_slot_count() > 0; t++) build_table(claim_header());
    full = seg_q.size();
    shape = $urandom_range(99);
    if (shape < 75) begin
      len = full;
      count = full;
    end else if (shape < 90) begin
      // Segment length cut short; the bytes past the end are sometimes sent anyway.
      len = $urandom_range(1, full - 1);
      count = $urandom_range(1) ? full : len;
    end else begin
      len = $urandom_range(full + 1, 65533);
      count = full;
    end
    send_segment(16'(len), count);
    open_seg = (shape >= 90);
  endtask

  task automatic error_header_segment();
    int slot;
    if (sb.defined != 0 && $urandom_range(1)) begin
      do slot = $urandom_range(31); while (!sb.defined[slot]);
      seg_q.push_back({3'b000, 5'(slot)});
    end else begin
      seg_q.push_back({4'($urandom_range(2, 15)), 4'($urandom)});
    end
    repeat ($urandom_range(0, 3)) seg_q.push_back(8'($urandom));
    send_segment(16'($urandom_range(1, 65533)), seg_q.size());
    open_seg = 1'b0;
  endtask

  task automatic random_phase(input int budget, input int slot_cap);
    int first;
    int pick;
    first = table_bytes_sent;
    while (table_bytes_sent - first < budget) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        // Stray bytes are only sent while the parser cannot take them as a header.
        if (!open_seg) repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0,
                                                                 16'($urandom));
      end else if (pick < 20 || $countones(sb.defined) >= slot_cap) begin
        error_header_segment();
      end else begin
        table_segment();
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // A stray byte while waiting and an empty segment are both ignored.
    send_byte(8'hFF, 1'b0, 16'hFFFF);
    send_byte(8'h00, 1'b1, 16'd0);
    // Class nibble out of range; the byte after it is skipped.
    send_byte(8'hF3, 1'b1, 16'd5);
    send_byte(8'hAA, 1'b0, 16'd0);
    // Empty DC table 0 that ends exactly at the segment end.
    send_byte(8'h00, 1'b1, 16'd17);
    repeat (16) send_byte(8'h00, 1'b0, 16'd0);
    // Table 0 a second time is a redefinition.
    send_byte(8'h00, 1'b1, 16'd3);
    // A one-bit code count is rejected at once.
    send_byte(8'h11, 1'b1, 16'd40);
    send_byte(8'h01, 1'b0, 16'd0);
    // The segment ends right after the first count.
    send_byte(8'h12, 1'b1, 16'd2);
    send_byte(8'h00, 1'b0, 16'd0);

    exact_table(PLAN_LONG_CODES);
    random_phase(650, 13);
    pause_until_drained();

    send_idle_pct = 87;
    recv_idle_pct = 25;
    random_phase(650, 23);
    pause_until_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    exact_table(PLAN_ALL_SYMBOLS);
    random_phase(600, 32);
    pause_until_drained();

    $display("Run covered %0d accepted bytes under three idle patterns.", sb.bytes_seen);
    $display("Checked %0d codewords, %0d completed tables and %0d error results.",
             sb.codes_seen, sb.tables_seen, sb.errors_seen);
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

/* jpeg_dht_canonical_code_builder.f */
design/dht_pkg.sv
design/jpeg_dht_canonical_code_builder.sv
test/tb_top.sv
